>>> rtl/ffsa_pkg.sv
// Shared constants, types and the per-word run scan for the seat allocator.
// No dependencies; used by ffsa_ram users and the top level.
package ffsa_pkg;

    localparam int SEATS  = 1024;
    localparam int WORD_W = 8;
    localparam int WORDS  = SEATS / WORD_W;
    localparam int ADDR_W = $clog2(WORDS);
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int SEAT_W = 10;
    localparam int LEN_W  = 11;
    localparam int CNT_W  = 32;

    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
        logic [LEN_W-1:0] run;
    } scan_res_t;

    // Walk one word lowest seat first, carrying the free-run length.
    function automatic scan_res_t scan_word(input logic [WORD_W-1:0] bits,
                                            input logic [LEN_W-1:0]  run_in,
                                            input logic [LEN_W-1:0]  len);
        scan_res_t r;
        r.found = 1'b0;
        r.pos   = '0;
        r.run   = run_in;
        for (int j = 0; j < WORD_W; j++) begin
            if (!r.found) begin
                if (bits[j]) begin
                    r.run = '0;
                end else begin
                    r.run = r.run + LEN_W'(1);
                    if (r.run == len) begin
                        r.found = 1'b1;
                        r.pos   = BIT_W'(j);
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/ffsa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

>>> rtl/first_fit_contiguous_seat_allocator.sv
// First-fit contiguous seat allocator: top level. Uses ffsa_pkg and ffsa_ram.
// The seat map lives in a 128 x 8 bitmap RAM, one bit per seat.
//
// After reset the block clears the bitmap, one word a cycle, with s_tready low. One
// transaction is worked at a time. An allocate reads the bitmap word by word (8 seats a
// cycle, reads pipelined behind the registered RAM read port) until a free run of the
// requested length ends, then writes back the words the run covers with a
// read-modify-write pass (one word a cycle). A release runs the same write-back pass over
// its range only. Invalid requests (zero length, longer than the map, inverted release)
// go straight to the response. Rate is set by the single bitmap read port and the
// per-word scan. The result sits in an output register, so it may wait for m_tready
// without losing data; the next transaction is taken once the result has been handed to
// that register.
module first_fit_contiguous_seat_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[0], run_length[11:1], first_seat[21:12], last_seat[31:22]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // granted[0], start_seat[10:1], refused_total[42:11], zero fill[47:43]
    output logic [47:0] m_tdata
);
    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_MARK, ST_RESP} state_t;

    localparam int AW = ffsa_pkg::ADDR_W;
    localparam int WW = ffsa_pkg::WORD_W;
    localparam int SW = ffsa_pkg::SEAT_W;
    localparam int LW = ffsa_pkg::LEN_W;
    localparam int CW = ffsa_pkg::CNT_W;

    state_t        state_reg, state_next;
    logic [AW-1:0] issue_addr_reg, issue_addr_next;
    logic          issue_done_reg, issue_done_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_word_reg, rd_word_next;
    logic [LW-1:0] run_reg, run_next;
    logic [LW-1:0] len_reg, len_next;
    logic [SW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic          set_reg, set_next;
    logic          res_granted_reg, res_granted_next;
    logic [SW-1:0] res_start_reg, res_start_next;
    logic [CW-1:0] refused_reg, refused_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [47:0]   m_tdata_reg, m_tdata_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [WW-1:0] wr_data, rd_data, mask;
    ffsa_pkg::scan_res_t sr;

    logic          in_op;
    logic [LW-1:0] in_len;
    logic [SW-1:0] in_first, in_last;
    logic [LW:0]   start_wide;
    logic          s_acc;

    assign in_op    = s_tdata[0];
    assign in_len   = s_tdata[11:1];
    assign in_first = s_tdata[21:12];
    assign in_last  = s_tdata[31:22];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ffsa_ram #(.WIDTH(WW), .DEPTH(ffsa_pkg::WORDS)) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign sr = ffsa_pkg::scan_word(rd_data, run_reg, len_reg);
    // start = last seat of the run + 1 - length
    assign start_wide = {1'b0, 1'b0, rd_word_reg, sr.pos} + (LW+1)'(1) - {1'b0, len_reg};

    // Seats of the word just read that fall inside [lo, hi].
    always_comb begin
        for (int j = 0; j < WW; j++) begin
            mask[j] = ({rd_word_reg, ffsa_pkg::BIT_W'(j)} >= lo_reg)
                   && ({rd_word_reg, ffsa_pkg::BIT_W'(j)} <= hi_reg);
        end
    end

    always_comb begin
        state_next       = state_reg;
        issue_addr_next  = issue_addr_reg;
        issue_done_next  = issue_done_reg;
        rd_valid_next    = 1'b0;
        rd_word_next     = issue_addr_reg;
        run_next         = run_reg;
        len_next         = len_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        set_next         = set_reg;
        res_granted_next = res_granted_reg;
        res_start_next   = res_start_reg;
        refused_next     = refused_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        wr_en            = 1'b0;
        wr_addr          = rd_word_reg;
        wr_data          = set_reg ? (rd_data | mask) : (rd_data & ~mask);
        rd_en            = 1'b0;
        rd_addr          = issue_addr_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                // wipe one word a cycle
                wr_en           = 1'b1;
                wr_addr         = issue_addr_reg;
                wr_data         = '0;
                issue_addr_next = issue_addr_reg + AW'(1);
                if (issue_addr_reg == AW'(ffsa_pkg::WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    issue_done_next = 1'b0;
                    if (in_op == ffsa_pkg::OP_RELEASE) begin
                        if (in_first > in_last) begin
                            res_granted_next = 1'b0;
                            res_start_next   = '0;
                            state_next       = ST_RESP;
                        end else begin
                            lo_next         = in_first;
                            hi_next         = in_last;
                            set_next        = 1'b0;
                            issue_addr_next = in_first[SW-1 -: AW];
                            state_next      = ST_MARK;
                        end
                    end else if (in_len == '0 || in_len > LW'(ffsa_pkg::SEATS)) begin
                        if (refused_reg != '1) begin
                            refused_next = refused_reg + CW'(1);
                        end
                        res_granted_next = 1'b0;
                        res_start_next   = '0;
                        state_next       = ST_RESP;
                    end else begin
                        len_next        = in_len;
                        run_next        = '0;
                        set_next        = 1'b1;
                        issue_addr_next = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!issue_done_reg) begin
                    rd_en           = 1'b1;
                    rd_valid_next   = 1'b1;
                    issue_addr_next = issue_addr_reg + AW'(1);
                    if (issue_addr_reg == AW'(ffsa_pkg::WORDS - 1)) begin
                        issue_done_next = 1'b1;
                    end
                end
                if (rd_valid_reg) begin
                    if (sr.found) begin
                        // drop the read in flight and start the write-back
                        lo_next          = start_wide[SW-1:0];
                        hi_next          = start_wide[SW-1:0] + len_reg[SW-1:0] - SW'(1);
                        res_granted_next = 1'b1;
                        res_start_next   = start_wide[SW-1:0];
                        issue_addr_next  = start_wide[SW-1 -: AW];
                        issue_done_next  = 1'b0;
                        rd_valid_next    = 1'b0;
                        state_next       = ST_MARK;
                    end else if (rd_word_reg == AW'(ffsa_pkg::WORDS - 1)) begin
                        if (refused_reg != '1) begin
                            refused_next = refused_reg + CW'(1);
                        end
                        res_granted_next = 1'b0;
                        res_start_next   = '0;
                        state_next       = ST_RESP;
                    end else begin
                        run_next = sr.run;
                    end
                end
            end
            ST_MARK: begin
                if (!issue_done_reg) begin
                    rd_en           = 1'b1;
                    rd_valid_next   = 1'b1;
                    issue_addr_next = issue_addr_reg + AW'(1);
                    if (issue_addr_reg == hi_reg[SW-1 -: AW]) begin
                        issue_done_next = 1'b1;
                    end
                end
                if (rd_valid_reg) begin
                    wr_en = 1'b1;
                    if (rd_word_reg == hi_reg[SW-1 -: AW]) begin
                        if (!set_reg) begin
                            res_granted_next = 1'b1;
                            res_start_next   = '0;
                        end
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, refused_reg, res_start_reg, res_granted_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            issue_addr_reg <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            refused_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_addr_reg <= issue_addr_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
            refused_reg    <= refused_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        rd_word_reg     <= rd_word_next;
        run_reg         <= run_next;
        len_reg         <= len_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        set_reg         <= set_next;
        res_granted_reg <= res_granted_next;
        res_start_reg   <= res_start_next;
        m_tdata_reg     <= m_tdata_next;
    end

    // The bitmap is only written while clearing or during a write-back pass.
    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_MARK))
        else $error("bitmap written outside clear or write-back");

    // The refusal count never goes down.
    a_refused_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> refused_reg >= $past(refused_reg))
        else $error("refusal count decreased");

    // A result is loaded only when the output register is free or being drained.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(m_tdata_reg))
        else $error("pending result overwritten");

    // No bitmap read or write is issued whenever a new transaction can be taken.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!rd_en && !wr_en))
        else $error("bitmap access while idle");
endmodule
